// File: hw/rtl/rgb_yuv_color_adjust_macros.svh
// Assertion helpers for the checker module ryca_chk.
`ifndef RGB_YUV_COLOR_ADJUST_MACROS_SVH
`define RGB_YUV_COLOR_ADJUST_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define RYCA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ryca: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define RYCA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ryca: next-cycle check failed");

`endif

// File: hw/rtl/ryca_pkg.sv
package ryca_pkg;

    // Pipeline depth: forward x2, divide x2, back conversion x2.
    localparam int NSTG = 6;

    // RGB to YUV, signed Q2.12.
    localparam int CY_R = 1225;
    localparam int CY_G = 2404;
    localparam int CY_B = 467;
    localparam int CU_R = -602;
    localparam int CU_G = -1184;
    localparam int CU_B = 1786;
    localparam int CV_R = 2519;
    localparam int CV_G = -2109;
    localparam int CV_B = -410;

    // YUV to RGB, signed Q2.12.
    localparam int CR_V = 4669;
    localparam int CG_U = -1622;
    localparam int CG_V = -2380;
    localparam int CB_U = 8311;

    // Rounding offsets: half of 1600 and half of 80000.
    localparam int Y_RND  = 800;
    localparam int UV_RND = 40000;

    // Chroma is pre-shifted by 7, leaving a divide by 625. A bias of 625 * 2^17
    // keeps the dividend non-negative; 2^17 is taken back off the quotient.
    localparam int UV_SHIFT = 7;
    localparam int UV_BIAS_Q = 131072;
    localparam int UV_BIAS   = 625 * UV_BIAS_Q;

    // Reciprocals ceil(2^38 / d) for d = 1600 and d = 625, exact over the
    // dividend ranges used here.
    localparam int RCP_SHIFT = 38;
    localparam logic [27:0] RCP_Y  = 28'd171798692;
    localparam logic [28:0] RCP_UV = 29'd439804652;

    // Tint chroma in Q8.
    localparam logic signed [17:0] TP_U = -18'sd2048;
    localparam logic signed [17:0] TP_V = 18'sd1280;
    localparam logic signed [17:0] TG_U = -18'sd25344;
    localparam logic signed [17:0] TG_V = -18'sd16384;
    localparam logic signed [17:0] TA_U = -18'sd26624;
    localparam logic signed [17:0] TA_V = 18'sd12800;
    localparam logic signed [17:0] TS_U = -18'sd7936;
    localparam logic signed [17:0] TS_V = 18'sd6656;

    localparam logic [6:0] BRIGHT_RST = 7'd50;
    localparam logic [6:0] CON_RST    = 7'd100;
    localparam logic [6:0] SAT_RST    = 7'd50;

    typedef enum logic [1:0] {
        CFG_BRIGHT   = 2'd0,
        CFG_CONTRAST = 2'd1,
        CFG_SAT      = 2'd2,
        CFG_TINT     = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        TINT_COLOR = 3'd0,
        TINT_BW    = 3'd1,
        TINT_PAPER = 3'd2,
        TINT_GREEN = 3'd3,
        TINT_AMBER = 3'd4,
        TINT_SEPIA = 3'd5
    } t_tint;

    typedef struct packed {
        logic [6:0] brightness;
        logic [6:0] contrast;
        logic [6:0] saturation;
        logic [2:0] tint_mode;
    } t_cfg;

    // Gain products with rounding offsets, before the divide.
    typedef struct packed {
        logic        [27:0] ny;
        logic signed [35:0] nu;
        logic signed [35:0] nv;
    } t_gain;

    // Q8 luma and chroma.
    typedef struct packed {
        logic signed [17:0] y;
        logic signed [17:0] u;
        logic signed [17:0] v;
    } t_yuv;

endpackage

// File: hw/rtl/ryca_in_if.sv
interface ryca_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

// File: hw/rtl/ryca_out_if.sv
interface ryca_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    input ready);
    modport sink (input valid, input red_out, input green_out, input blue_out,
                  output ready);
endinterface

// File: hw/rtl/ryca_fwd.sv
// RGB to Q12 YUV, then apply contrast and saturation gains.
module ryca_fwd import ryca_pkg::*; (
    input  logic       i_clk,
    input  logic       i_en,
    input  t_cfg       i_cfg,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    output t_gain      o_gain
);
    logic signed [31:0] w_r, w_g, w_b, w_y, w_u, w_v;
    logic        [19:0] r_y12;
    logic signed [20:0] r_u12, r_v12;
    logic        [13:0] r_sc;
    t_gain              r_gain;
    t_gain              n_gain;

    assign w_r = signed'(32'(i_red));
    assign w_g = signed'(32'(i_green));
    assign w_b = signed'(32'(i_blue));
    assign w_y = CY_R * w_r + CY_G * w_g + CY_B * w_b;
    assign w_u = CU_R * w_r + CU_G * w_g + CU_B * w_b;
    assign w_v = CV_R * w_r + CV_G * w_g + CV_B * w_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y12 <= w_y[19:0];
            r_u12 <= w_u[20:0];
            r_v12 <= w_v[20:0];
            r_sc  <= 14'(i_cfg.saturation) * 14'(i_cfg.contrast);
        end
    end

    always_comb begin
        n_gain.ny = 28'(r_y12) * 28'(i_cfg.contrast) + 28'(Y_RND);
        n_gain.nu = 36'(r_u12) * $signed(36'(r_sc)) + 36'(UV_RND);
        n_gain.nv = 36'(r_v12) * $signed(36'(r_sc)) + 36'(UV_RND);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_gain <= n_gain;
        end
    end

    assign o_gain = r_gain;
endmodule

// File: hw/rtl/ryca_div.sv
// Divide by 1600 and 80000 through reciprocal products, then add the
// brightness offset and apply the tint.
module ryca_div import ryca_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_cfg  i_cfg,
    input  t_gain i_gain,
    output t_yuv  o_yuv
);
    logic signed [35:0] w_su, w_sv;
    logic        [27:0] w_au, w_av;
    logic        [55:0] r_py;
    logic        [56:0] r_pu, r_pv;
    logic        [16:0] w_qy;
    logic        [18:0] w_qu, w_qv;
    t_yuv               n_yuv;
    t_yuv               r_yuv;

    // Floor by 128, then bias to a non-negative dividend.
    assign w_su = (i_gain.nu >>> UV_SHIFT) + 36'(UV_BIAS);
    assign w_sv = (i_gain.nv >>> UV_SHIFT) + 36'(UV_BIAS);
    assign w_au = w_su[27:0];
    assign w_av = w_sv[27:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_py <= 56'(i_gain.ny) * 56'(RCP_Y);
            r_pu <= 57'(w_au) * 57'(RCP_UV);
            r_pv <= 57'(w_av) * 57'(RCP_UV);
        end
    end

    assign w_qy = r_py[RCP_SHIFT +: 17];
    assign w_qu = r_pu[RCP_SHIFT +: 19];
    assign w_qv = r_pv[RCP_SHIFT +: 19];

    always_comb begin
        n_yuv.y = 18'($signed(20'(w_qy))
                      + (($signed(20'(i_cfg.brightness)) - 20'sd50) <<< 8));
        n_yuv.u = 18'($signed(20'(w_qu)) - 20'(UV_BIAS_Q));
        n_yuv.v = 18'($signed(20'(w_qv)) - 20'(UV_BIAS_Q));
        unique case (t_tint'(i_cfg.tint_mode))
            TINT_BW: begin
                n_yuv.u = '0;
                n_yuv.v = '0;
            end
            TINT_PAPER: begin
                n_yuv.u = TP_U;
                n_yuv.v = TP_V;
            end
            TINT_GREEN: begin
                n_yuv.u = TG_U;
                n_yuv.v = TG_V;
            end
            TINT_AMBER: begin
                n_yuv.u = TA_U;
                n_yuv.v = TA_V;
            end
            TINT_SEPIA: begin
                n_yuv.u = TS_U;
                n_yuv.v = TS_V;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_yuv <= n_yuv;
        end
    end

    assign o_yuv = r_yuv;
endmodule

// File: hw/rtl/ryca_back.sv
// Q8 YUV back to RGB in Q20, then clamp to a byte.
module ryca_back import ryca_pkg::*; (
    input  logic       i_clk,
    input  logic       i_en,
    input  t_yuv       i_yuv,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue
);
    logic signed [31:0] w_ys, w_u, w_v;
    logic signed [31:0] r_sr, r_sg, r_sb;
    logic        [7:0]  r_red, r_green, r_blue;

    // Negative gives 0, anything at or above 256.0 gives 255.
    function automatic logic [7:0] to_byte(input logic signed [31:0] s);
        logic [7:0] b;
        if (s[31]) begin
            b = 8'd0;
        end else if (|s[30:28]) begin
            b = 8'hff;
        end else begin
            b = s[27:20];
        end
        return b;
    endfunction

    assign w_ys = 32'(i_yuv.y) <<< 12;
    assign w_u  = 32'(i_yuv.u);
    assign w_v  = 32'(i_yuv.v);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sr <= w_ys + CR_V * w_v;
            r_sg <= w_ys + CG_U * w_u + CG_V * w_v;
            r_sb <= w_ys + CB_U * w_u;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_red   <= to_byte(r_sr);
            r_green <= to_byte(r_sg);
            r_blue  <= to_byte(r_sb);
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;
endmodule

// File: hw/rtl/rgb_yuv_color_adjust.sv
// Brightness, contrast, saturation and tint adjust for an RGB pixel stream.
// Each pixel is converted to YUV, scaled by contrast/100 (and chroma by
// saturation/50), offset by brightness-50 on luma, optionally replaced by a
// fixed tint chroma, converted back and clamped to 0..255. The block takes one
// item per clock unless o_pix stalls: two stages of RGB-to-YUV and gain
// products, two of reciprocal-multiply division (divisors 1600 and
// 80000) and tint, two of YUV-to-RGB and clamping. The whole pipeline advances
// together, so i_pix.ready is high whenever the output register is empty or
// its item is taken in the same cycle; a stall on o_pix freezes every stage
// in place. Configuration is four registers on the plain write port (index 0
// brightness, 1 contrast, 2 saturation, 3 tint mode), reset to 50, 100, 50
// and color; write them only while no item is in flight. Tint codes 6 and 7
// act as color. There is no clearing pass after reset.
module rgb_yuv_color_adjust import ryca_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ryca_in_if.sink    i_pix,
    ryca_out_if.source o_pix,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [6:0] i_cfg_data
);
    t_cfg             r_cfg;
    logic [NSTG-1:0]  r_vld;
    logic             w_en;
    t_gain            w_gain;
    t_yuv             w_yuv;

    // Advance the whole pipeline unless the output holds an item not taken.
    assign w_en        = !r_vld[NSTG-1] || o_pix.ready;
    assign i_pix.ready = w_en;
    assign o_pix.valid = r_vld[NSTG-1];

    // Valid bits travel alongside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_pix.valid};
        end
    end

    // Configuration registers; hold unless written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.brightness <= BRIGHT_RST;
            r_cfg.contrast   <= CON_RST;
            r_cfg.saturation <= SAT_RST;
            r_cfg.tint_mode  <= TINT_COLOR;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_BRIGHT:   r_cfg.brightness <= i_cfg_data;
                CFG_CONTRAST: r_cfg.contrast   <= i_cfg_data;
                CFG_SAT:      r_cfg.saturation <= i_cfg_data;
                CFG_TINT:     r_cfg.tint_mode  <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    // Stages 1-2: color transform and gain products.
    ryca_fwd u_fwd (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_cfg   (r_cfg),
        .i_red   (i_pix.red_in),
        .i_green (i_pix.green_in),
        .i_blue  (i_pix.blue_in),
        .o_gain  (w_gain)
    );

    // Stages 3-4: rounding divide, brightness offset, tint.
    ryca_div u_div (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_cfg  (r_cfg),
        .i_gain (w_gain),
        .o_yuv  (w_yuv)
    );

    // Stages 5-6: back to RGB, clamp into the output register.
    ryca_back u_back (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_yuv   (w_yuv),
        .o_red   (o_pix.red_out),
        .o_green (o_pix.green_out),
        .o_blue  (o_pix.blue_out)
    );
endmodule

// File: hw/rtl/ryca_chk.sv
`include "rgb_yuv_color_adjust_macros.svh"

module ryca_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_red,
    input logic [7:0] i_green,
    input logic [7:0] i_blue
);
    logic        w_stall;
    logic [23:0] w_pix;

    assign w_stall = i_out_valid && !i_out_ready;
    assign w_pix   = {i_red, i_green, i_blue};

    // An empty output register must never block the input.
    `RYCA_ASSERT_IMP(a_ready_when_empty, i_clk, i_rst_n, !i_out_valid, i_in_ready)

    // A stalled output freezes the pipeline, so no item may enter.
    `RYCA_ASSERT_IMP(a_no_accept_on_stall, i_clk, i_rst_n, w_stall, !i_in_ready)

    // A stalled item stays put.
    `RYCA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, w_stall, i_out_valid && $stable(w_pix))
endmodule

bind rgb_yuv_color_adjust ryca_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_red       (o_pix.red_out),
    .i_green     (o_pix.green_out),
    .i_blue      (o_pix.blue_out)
);
